// ----- hw/rtl/psk_pkg.sv -----
// ----------------------------------------------------------------------------
// psk_pkg
// Scan code set 1 constants, lookup tables and modifier helpers.
// ----------------------------------------------------------------------------
package psk_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_pos;

    localparam t_byte PFX_E0      = 8'hE0;
    localparam t_byte PFX_E1      = 8'hE1;
    localparam t_byte SINGLE_MAX  = 8'h58;
    localparam t_byte EXT_MIN     = 8'h1C;
    localparam t_byte EXT_MAX     = 8'h5C;
    localparam t_byte PAUSE_2ND   = 8'h1D;
    localparam t_byte PAUSE_3RD   = 8'h45;

    localparam t_pos  POS_FIRST   = 2'd0;
    localparam t_pos  POS_SECOND  = 2'd1;
    localparam t_pos  POS_THIRD   = 2'd2;

    localparam t_byte KEY_NONE        = 8'h00;
    localparam t_byte KEY_PAUSE       = 8'h13;
    localparam t_byte KEY_CAPS_LOCK   = 8'h14;
    localparam t_byte KEY_NUM_LOCK    = 8'h90;
    localparam t_byte KEY_SCROLL_LOCK = 8'h91;
    localparam t_byte KEY_LEFT_SHIFT  = 8'hA0;
    localparam t_byte KEY_RIGHT_SHIFT = 8'hA1;
    localparam t_byte KEY_LEFT_CTRL   = 8'hA2;
    localparam t_byte KEY_RIGHT_CTRL  = 8'hA3;
    localparam t_byte KEY_LEFT_ALT    = 8'hA4;
    localparam t_byte KEY_RIGHT_ALT   = 8'hA5;

    localparam t_byte MOD_RALT    = 8'h01;
    localparam t_byte MOD_LALT    = 8'h02;
    localparam t_byte MOD_RCTRL   = 8'h04;
    localparam t_byte MOD_LCTRL   = 8'h08;
    localparam t_byte MOD_SHIFT   = 8'h10;
    localparam t_byte MOD_NUM     = 8'h20;
    localparam t_byte MOD_SCROLL  = 8'h40;
    localparam t_byte MOD_CAPS    = 8'h80;
    localparam t_byte MOD_LOCKS   = MOD_NUM | MOD_SCROLL | MOD_CAPS;

    localparam int CAPS_BIT   = 7;
    localparam int NUM_BIT    = 5;
    localparam int SCROLL_BIT = 6;

    function automatic t_byte single_vk(input logic [6:0] code);
        t_byte vk;
        case (code)
            7'h01: vk = 8'h1B;  7'h02: vk = 8'h31;  7'h03: vk = 8'h32;  7'h04: vk = 8'h33;
            7'h05: vk = 8'h34;  7'h06: vk = 8'h35;  7'h07: vk = 8'h36;  7'h08: vk = 8'h37;
            7'h09: vk = 8'h38;  7'h0A: vk = 8'h39;  7'h0B: vk = 8'h30;  7'h0C: vk = 8'hBD;
            7'h0D: vk = 8'hBB;  7'h0E: vk = 8'h08;  7'h0F: vk = 8'h09;  7'h10: vk = 8'h51;
            7'h11: vk = 8'h57;  7'h12: vk = 8'h45;  7'h13: vk = 8'h52;  7'h14: vk = 8'h54;
            7'h15: vk = 8'h59;  7'h16: vk = 8'h55;  7'h17: vk = 8'h49;  7'h18: vk = 8'h4F;
            7'h19: vk = 8'h50;  7'h1A: vk = 8'hDB;  7'h1B: vk = 8'hDD;  7'h1C: vk = 8'h0D;
            7'h1D: vk = 8'hA2;  7'h1E: vk = 8'h41;  7'h1F: vk = 8'h53;  7'h20: vk = 8'h44;
            7'h21: vk = 8'h46;  7'h22: vk = 8'h47;  7'h23: vk = 8'h48;  7'h24: vk = 8'h4A;
            7'h25: vk = 8'h4B;  7'h26: vk = 8'h4C;  7'h27: vk = 8'hBA;  7'h28: vk = 8'hDE;
            7'h29: vk = 8'hC0;  7'h2A: vk = 8'hA0;  7'h2B: vk = 8'hDC;  7'h2C: vk = 8'h5A;
            7'h2D: vk = 8'h58;  7'h2E: vk = 8'h43;  7'h2F: vk = 8'h56;  7'h30: vk = 8'h42;
            7'h31: vk = 8'h4E;  7'h32: vk = 8'h4D;  7'h33: vk = 8'hBC;  7'h34: vk = 8'hBE;
            7'h35: vk = 8'hBF;  7'h36: vk = 8'hA1;  7'h37: vk = 8'h6A;  7'h38: vk = 8'hA4;
            7'h39: vk = 8'h20;  7'h3A: vk = 8'h14;  7'h3B: vk = 8'h70;  7'h3C: vk = 8'h71;
            7'h3D: vk = 8'h72;  7'h3E: vk = 8'h73;  7'h3F: vk = 8'h74;  7'h40: vk = 8'h75;
            7'h41: vk = 8'h76;  7'h42: vk = 8'h77;  7'h43: vk = 8'h78;  7'h44: vk = 8'h79;
            7'h45: vk = 8'h90;  7'h46: vk = 8'h91;  7'h47: vk = 8'h67;  7'h48: vk = 8'h68;
            7'h49: vk = 8'h69;  7'h4A: vk = 8'h6D;  7'h4B: vk = 8'h64;  7'h4C: vk = 8'h65;
            7'h4D: vk = 8'h66;  7'h4E: vk = 8'h6B;  7'h4F: vk = 8'h61;  7'h50: vk = 8'h62;
            7'h51: vk = 8'h63;  7'h52: vk = 8'h60;  7'h53: vk = 8'h6E;  7'h54: vk = 8'h2A;
            7'h57: vk = 8'h7A;  7'h58: vk = 8'h7B;
            default: vk = KEY_NONE;
        endcase
        return vk;
    endfunction

    function automatic t_byte ext_vk(input logic [6:0] code);
        t_byte vk;
        case (code)
            7'h1C: vk = 8'h6C;  7'h1D: vk = 8'hA3;  7'h35: vk = 8'h6F;  7'h37: vk = 8'h2A;
            7'h38: vk = 8'hA5;  7'h46: vk = 8'h13;  7'h47: vk = 8'h24;  7'h48: vk = 8'h26;
            7'h49: vk = 8'h21;  7'h4B: vk = 8'h25;  7'h4D: vk = 8'h27;  7'h4F: vk = 8'h23;
            7'h50: vk = 8'h28;  7'h51: vk = 8'h22;  7'h52: vk = 8'h2D;  7'h53: vk = 8'h2E;
            7'h5B: vk = 8'h5B;  7'h5C: vk = 8'h5C;
            default: vk = KEY_NONE;
        endcase
        return vk;
    endfunction

    function automatic t_byte modifier_mask(input t_byte vk);
        t_byte m;
        case (vk)
            KEY_RIGHT_ALT:   m = MOD_RALT;
            KEY_LEFT_ALT:    m = MOD_LALT;
            KEY_RIGHT_CTRL:  m = MOD_RCTRL;
            KEY_LEFT_CTRL:   m = MOD_LCTRL;
            KEY_LEFT_SHIFT:  m = MOD_SHIFT;
            KEY_RIGHT_SHIFT: m = MOD_SHIFT;
            KEY_CAPS_LOCK:   m = MOD_CAPS;
            KEY_NUM_LOCK:    m = MOD_NUM;
            KEY_SCROLL_LOCK: m = MOD_SCROLL;
            default:         m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] led_pattern(input t_byte st);
        return {st[CAPS_BIT], st[NUM_BIT], st[SCROLL_BIT]};
    endfunction

endpackage

// ----- hw/rtl/psk_if.sv -----
// ----------------------------------------------------------------------------
// psk_if
// Valid/ready channels for scan bytes and key event words.
// ----------------------------------------------------------------------------
interface psk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface psk_event_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic [7:0] virtual_key;
    logic [7:0] modifier_flags;
    logic       led_update;
    logic [2:0] led_bits;

    modport source (output valid, output key_down, output virtual_key,
                    output modifier_flags, output led_update, output led_bits,
                    input ready);
    modport sink   (input valid, input key_down, input virtual_key,
                    input modifier_flags, input led_update, input led_bits,
                    output ready);
endinterface

// ----- hw/rtl/ps2_scancode_key_event_decoder_core.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_key_event_decoder_core
// Scan code set 1 byte stream to key event decoder with modifier tracking.
// ----------------------------------------------------------------------------
// Usage:
//   i_scan carries one raw keyboard byte per word. o_event carries one key
//   event word per recognized key: make/break, virtual key, modifier flags,
//   and an led update flag with the led pattern for the current lock state.
//   Prefix bytes (E0, E1), unmapped codes, fake shifts and pause release give
//   no event word.
//   A byte is taken into an input register, then decoded through a short
//   table lookup into the event register. Throughput: one byte per cycle
//   while o_event does not stall, with a single decode stage between the
//   input and event registers.
//   The input register keeps accepting while an event word waits, as long as
//   the word it holds can move on; when o_event stalls, both registers fill
//   and i_scan.ready drops until the event word is taken.
//   Reset clears the byte position, the held prefix codes, the modifier and
//   lock state and both valid flags.
// ----------------------------------------------------------------------------
module ps2_scancode_key_event_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psk_byte_if.sink           i_scan,
    psk_event_if.source        o_event
);
    import psk_pkg::*;

    logic       r_in_valid;
    t_byte      r_in_byte;
    t_byte      r_first;
    t_byte      r_second;
    t_pos       r_pos;
    t_byte      r_mod;

    logic       r_out_valid;
    logic       r_out_down;
    t_byte      r_out_vk;
    t_byte      r_out_mod;
    logic       r_out_upd;

    logic       advance;
    t_byte      n_first;
    t_byte      n_second;
    t_pos       n_pos;
    t_byte      n_mod;
    logic       down;
    t_byte      vk;
    t_byte      mask;
    logic       upd;

    assign advance       = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_scan.ready  = !r_in_valid || advance;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_pos    = POS_FIRST;
        n_mod    = r_mod;
        down     = 1'b0;
        vk       = KEY_NONE;
        upd      = 1'b0;
        case (r_pos)
            POS_FIRST: begin
                n_first = r_in_byte;
                if (r_in_byte == PFX_E0 || r_in_byte == PFX_E1) begin
                    n_pos = POS_SECOND;
                end else begin
                    down = ~r_in_byte[7];
                    if ({1'b0, r_in_byte[6:0]} <= SINGLE_MAX) begin
                        vk = single_vk(r_in_byte[6:0]);
                    end
                end
            end
            POS_SECOND: begin
                n_second = r_in_byte;
                if (r_first == PFX_E1) begin
                    n_pos = POS_THIRD;
                end else begin
                    down = ~r_in_byte[7];
                    if ({1'b0, r_in_byte[6:0]} >= EXT_MIN
                            && {1'b0, r_in_byte[6:0]} <= EXT_MAX) begin
                        vk = ext_vk(r_in_byte[6:0]);
                    end
                end
            end
            default: begin
                if (r_second == PAUSE_2ND && r_in_byte == PAUSE_3RD) begin
                    down = 1'b1;
                    vk   = KEY_PAUSE;
                end
            end
        endcase
        mask = modifier_mask(vk);
        if ((mask & MOD_LOCKS) != 8'h00) begin
            if (down) begin
                n_mod = r_mod ^ mask;
                upd   = 1'b1;
            end
        end else if (down) begin
            n_mod = r_mod | mask;
        end else begin
            n_mod = r_mod & ~mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_pos       <= POS_FIRST;
            r_mod       <= '0;
        end else begin
            if (i_scan.valid && i_scan.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_first     <= n_first;
                r_second    <= n_second;
                r_pos       <= n_pos;
                r_mod       <= n_mod;
                r_out_valid <= (vk != KEY_NONE);
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_in_byte <= i_scan.scan_byte;
        end
        if (advance) begin
            r_out_down <= down;
            r_out_vk   <= vk;
            r_out_mod  <= n_mod;
            r_out_upd  <= upd;
        end
    end

    assign o_event.valid          = r_out_valid;
    assign o_event.key_down       = r_out_down;
    assign o_event.virtual_key    = r_out_vk;
    assign o_event.modifier_flags = r_out_mod;
    assign o_event.led_update     = r_out_upd;
    assign o_event.led_bits       = led_pattern(r_out_mod);

endmodule

// ----- hw/rtl/psk_checker.sv -----
// ----------------------------------------------------------------------------
// psk_checker
// Port-level checks on the key event decoder outputs.
// ----------------------------------------------------------------------------
module psk_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_key_down,
    input  logic [7:0] i_virtual_key,
    input  logic [7:0] i_modifier_flags,
    input  logic       i_led_update,
    input  logic [2:0] i_led_bits
);
    import psk_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_virtual_key)
            && $stable(i_modifier_flags))
        else $error("event word changed while stalled");

    a_vk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_virtual_key != KEY_NONE)
        else $error("event word with empty virtual key");

    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_led_bits == led_pattern(i_modifier_flags))
        else $error("led bits disagree with lock flags");

    a_led_lock_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_led_update |-> i_key_down
            && (i_virtual_key == KEY_CAPS_LOCK || i_virtual_key == KEY_NUM_LOCK
                || i_virtual_key == KEY_SCROLL_LOCK))
        else $error("led update without lock key press");

endmodule

bind ps2_scancode_key_event_decoder_core psk_checker u_psk_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_event.valid),
    .i_out_ready      (o_event.ready),
    .i_key_down       (o_event.key_down),
    .i_virtual_key    (o_event.virtual_key),
    .i_modifier_flags (o_event.modifier_flags),
    .i_led_update     (o_event.led_update),
    .i_led_bits       (o_event.led_bits)
);

// ----- tb/sv/ps2_scancode_key_event_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// ps2_scancode_key_event_decoder_core_tb
// Drives scan code set 1 bytes into the decoder with random source gaps and
// sink stalls, predicts each key event word and modifier state, and checks
// every accepted event word against the oldest prediction.
// ----------------------------------------------------------------------------
module ps2_scancode_key_event_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psk_pkg::*;

    typedef struct packed {
        logic       key_down;
        logic [7:0] virtual_key;
        logic [7:0] modifier_flags;
        logic       led_update;
        logic [2:0] led_bits;
    } t_key_event;

    class key_event_board;
        logic [7:0] base_map [89];
        logic [7:0] ext_map [65];
        logic [7:0] held_first;
        logic [7:0] held_second;
        logic [1:0] seq_pos;
        logic [7:0] mod_state;
        t_key_event pending_events [$];
        int         mismatches;

        function new();
            base_map = '{
                'h00, 'h1B, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
                'h37, 'h38, 'h39, 'h30, 'hBD, 'hBB, 'h08, 'h09,
                'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
                'h4F, 'h50, 'hDB, 'hDD, 'h0D, 'hA2, 'h41, 'h53,
                'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'hBA,
                'hDE, 'hC0, 'hA0, 'hDC, 'h5A, 'h58, 'h43, 'h56,
                'h42, 'h4E, 'h4D, 'hBC, 'hBE, 'hBF, 'hA1, 'h6A,
                'hA4, 'h20, 'h14, 'h70, 'h71, 'h72, 'h73, 'h74,
                'h75, 'h76, 'h77, 'h78, 'h79, 'h90, 'h91, 'h67,
                'h68, 'h69, 'h6D, 'h64, 'h65, 'h66, 'h6B, 'h61,
                'h62, 'h63, 'h60, 'h6E, 'h2A, 'h00, 'h00, 'h7A,
                'h7B};
            // extended codes starting at 0x1c
            ext_map = '{
                'h6C, 'hA3, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
                'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
                'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
                'h00, 'h6F, 'h00, 'h2A, 'hA5, 'h00, 'h00, 'h00,
                'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
                'h00, 'h00, 'h13, 'h24, 'h26, 'h21, 'h00, 'h25,
                'h00, 'h27, 'h00, 'h23, 'h28, 'h22, 'h2D, 'h2E,
                'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h5B,
                'h5C};
            held_first  = 8'h00;
            held_second = 8'h00;
            seq_pos     = POS_FIRST;
            mod_state   = 8'h00;
            mismatches  = 0;
        endfunction

        function logic [7:0] key_modifier(logic [7:0] vk);
            case (vk)
                KEY_RIGHT_ALT:                   return MOD_RALT;
                KEY_LEFT_ALT:                    return MOD_LALT;
                KEY_RIGHT_CTRL:                  return MOD_RCTRL;
                KEY_LEFT_CTRL:                   return MOD_LCTRL;
                KEY_LEFT_SHIFT, KEY_RIGHT_SHIFT: return MOD_SHIFT;
                KEY_CAPS_LOCK:                   return MOD_CAPS;
                KEY_NUM_LOCK:                    return MOD_NUM;
                KEY_SCROLL_LOCK:                 return MOD_SCROLL;
                default:                         return 8'h00;
            endcase
        endfunction

        function void decode_byte(logic [7:0] b);
            logic       dn;
            logic [7:0] code;
            logic [7:0] vk;
            logic [7:0] m;
            logic       upd;
            t_key_event e;
            dn   = ~b[7];
            code = {1'b0, b[6:0]};
            vk   = KEY_NONE;
            upd  = 1'b0;
            case (seq_pos)
                POS_FIRST: begin
                    held_first = b;
                    if (b == PFX_E0 || b == PFX_E1) begin
                        seq_pos = POS_SECOND;
                        return;
                    end
                    if (code <= SINGLE_MAX) vk = base_map[code[6:0]];
                end
                POS_SECOND: begin
                    held_second = b;
                    if (held_first == PFX_E1) begin
                        seq_pos = POS_THIRD;
                        return;
                    end
                    if (code >= EXT_MIN && code <= EXT_MAX)
                        vk = ext_map[7'(code - EXT_MIN)];
                end
                default: begin
                    dn = 1'b1;
                    if (held_second == PAUSE_2ND && b == PAUSE_3RD) vk = KEY_PAUSE;
                end
            endcase
            seq_pos = POS_FIRST;
            if (vk == KEY_NONE) return;
            m = key_modifier(vk);
            if ((m & MOD_LOCKS) != 8'h00) begin
                if (dn) begin
                    mod_state = mod_state ^ m;
                    upd = 1'b1;
                end
            end else if (dn) begin
                mod_state = mod_state | m;
            end else begin
                mod_state = mod_state & ~m;
            end
            e.key_down       = dn;
            e.virtual_key    = vk;
            e.modifier_flags = mod_state;
            e.led_update     = upd;
            e.led_bits       = {|(mod_state & MOD_CAPS), |(mod_state & MOD_NUM),
                                |(mod_state & MOD_SCROLL)};
            pending_events.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_key_event(t_key_event got);
            t_key_event e;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected event word, vk %02h", got.virtual_key));
                return;
            end
            e = pending_events.pop_front();
            if (got.key_down !== e.key_down)
                report($sformatf("key_down %b, want %b (vk %02h)", got.key_down, e.key_down,
                                 e.virtual_key));
            if (got.virtual_key !== e.virtual_key)
                report($sformatf("virtual_key %02h, want %02h", got.virtual_key,
                                 e.virtual_key));
            if (got.modifier_flags !== e.modifier_flags)
                report($sformatf("modifier_flags %02h, want %02h (vk %02h)",
                                 got.modifier_flags, e.modifier_flags, e.virtual_key));
            if (got.led_update !== e.led_update)
                report($sformatf("led_update %b, want %b (vk %02h)", got.led_update,
                                 e.led_update, e.virtual_key));
            if (got.led_bits !== e.led_bits)
                report($sformatf("led_bits %03b, want %03b (vk %02h)", got.led_bits,
                                 e.led_bits, e.virtual_key));
        endtask

        function int pending();
            return pending_events.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 1800;
    localparam int PHASE_BYTES    = 150;
    localparam int QUIET_FROM     = 1500;

    logic i_clk;
    logic i_rst_n;

    psk_byte_if  scan_ch ();
    psk_event_if key_ch ();

    ps2_scancode_key_event_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_ch),
        .o_event (key_ch)
    );

    key_event_board board;
    logic           src_idle_en;
    logic           snk_idle_en;
    int             sent_bytes;
    int             stall_left;
    int             quiet_cycles = 0;

    logic [7:0] mod_codes [7] = '{8'h2A, 8'h36, 8'h1D, 8'h38, 8'h3A, 8'h45, 8'h46};
    logic [7:0] directed_bytes [27] = '{
        8'h00, 8'h01, 8'h81, 8'h58, 8'h59, 8'hFF,
        8'h3A, 8'hBA, 8'h45, 8'h46, 8'h2A, 8'hAA,
        8'hE0, 8'h38, 8'hE0, 8'hAA, 8'hE0, 8'hE1,
        8'hE1, 8'h1D, 8'h45, 8'hE1, 8'h9D, 8'hC5,
        8'hE1, 8'hE0, 8'h45};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            scan_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        scan_ch.valid     <= 1'b1;
        scan_ch.scan_byte <= b;
        @(posedge i_clk);
        while (!scan_ch.ready) @(posedge i_clk);
        board.decode_byte(b);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_random_sequence();
        int         pick;
        logic       brk;
        logic [6:0] code;
        pick = $urandom_range(0, 99);
        brk  = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            code = 7'($urandom_range(1, 'h58));
            send_byte({brk, code});
        end else if (pick < 55) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(PFX_E0);
                code = ($urandom_range(0, 1) != 0) ? 7'h1D : 7'h38;
            end else begin
                code = mod_codes[3'($urandom_range(0, 6))][6:0];
            end
            send_byte({brk, code});
        end else if (pick < 75) begin
            send_byte(PFX_E0);
            if ($urandom_range(0, 4) != 0) code = 7'($urandom_range('h1C, 'h5C));
            else code = 7'($urandom_range(0, 'h7F));
            send_byte({brk, code});
        end else if (pick < 83) begin
            send_byte(PFX_E1);
            send_byte(brk ? 8'h9D : 8'h1D);
            send_byte(brk ? 8'hC5 : 8'h45);
        end else if (pick < 93) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(PFX_E1);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        board             = new();
        i_rst_n           = 1'b0;
        scan_ch.valid     = 1'b0;
        scan_ch.scan_byte = 8'h00;
        src_idle_en       = 1'b0;
        snk_idle_en       = 1'b0;
        sent_bytes        = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        while (sent_bytes < RANDOM_BYTES) begin
            if (sent_bytes % PHASE_BYTES < 3) begin
                src_idle_en = (sent_bytes < QUIET_FROM) && ($urandom_range(0, 2) != 0);
                snk_idle_en = (sent_bytes < QUIET_FROM) && ($urandom_range(0, 2) != 0);
            end
            send_random_sequence();
        end
        scan_ch.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("ps2_scancode_key_event_decoder_core test passed");
        else
            $display("ps2_scancode_key_event_decoder_core test failed");
        $finish;
    end

    // sink side stall bursts
    initial begin
        stall_left   = 0;
        key_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                key_ch.ready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                key_ch.ready <= 1'b0;
            end else begin
                key_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && key_ch.valid && key_ch.ready)
            board.check_key_event({key_ch.key_down, key_ch.virtual_key, key_ch.modifier_flags,
                                   key_ch.led_update, key_ch.led_bits});
    end

    always @(posedge i_clk) begin
        if ((scan_ch.valid && scan_ch.ready) || (key_ch.valid && key_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ps2_scancode_key_event_decoder_core test failed");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/psk_pkg.sv
hw/rtl/psk_if.sv
hw/rtl/ps2_scancode_key_event_decoder_core.sv
hw/rtl/psk_checker.sv
tb/sv/ps2_scancode_key_event_decoder_core_tb.sv
